// ----- rtl/smseq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the stepper move sequencer.
// No dependencies; used by every module under rtl/.
package smseq_pkg;

    localparam int          POS_WIDTH_DEF = 32;
    localparam logic [15:0] PERIOD_RESET  = 16'd1000;
    localparam logic [31:0] CONT_TARGET   = 32'hffff_ffff;

    localparam logic [1:0]  DIR_REV = 2'd0;
    localparam logic [1:0]  DIR_FWD = 2'd2;

    typedef enum logic [2:0] {
        FUNC_TICK     = 3'd0,
        FUNC_ABS_MOVE = 3'd1,
        FUNC_REL_TURN = 3'd2,
        FUNC_CONT_RUN = 3'd3,
        FUNC_RESET    = 3'd4,
        FUNC_START    = 3'd5
    } t_func;

    // one command beat as seen by the core
    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] speed;
        logic [1:0]  direction;
        logic [31:0] angle_value;
    } t_cmd;

    // one result beat
    typedef struct packed {
        logic               finished;
        logic [31:0]        steps_done;
        logic signed [31:0] position;
        logic [15:0]        compare_value;
        logic [16:0]        counter_load;
        logic               dir_level;
        logic               drive_enable;
        logic               running;
    } t_result;

endpackage

// ----- rtl/smseq_ingress.sv -----
`timescale 1ns / 1ps
// Input register stage: holds one command beat until the core takes it.
// Depends on smseq_pkg.
module smseq_ingress (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  smseq_pkg::t_cmd    i_cmd,
    input  logic               i_take,
    output logic               o_valid,
    output smseq_pkg::t_cmd    o_cmd
);

    logic            r_valid;
    smseq_pkg::t_cmd r_cmd;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= i_cmd;
        end
    end

endmodule

// ----- rtl/smseq_core.sv -----
`timescale 1ns / 1ps
// Move state and single-pass command execution; computes the result beat.
// Depends on smseq_pkg.
module smseq_core #(
    parameter int POS_WIDTH = smseq_pkg::POS_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_exec,
    input  smseq_pkg::t_cmd     i_cmd,
    output smseq_pkg::t_result  o_res
);

    localparam int PW_EXT = (POS_WIDTH > 32) ? POS_WIDTH : 32;

    logic [15:0]          r_period;
    logic                 r_run,      n_run;
    logic [POS_WIDTH-1:0] r_position, n_position;
    logic [31:0]          r_target,   n_target;
    logic [31:0]          r_step,     n_step;
    logic [15:0]          r_speed,    n_speed;
    logic [1:0]           r_dir,      n_dir;
    logic                 r_pin,      n_pin;

    logic [15:0]          w_speed_clamped;
    logic [PW_EXT-1:0]    w_pos_ext;
    logic [PW_EXT-1:0]    w_npos_ext;
    logic [31:0]          w_diff;
    logic                 w_positive;
    logic                 w_drive;
    logic                 w_fin;

    assign w_speed_clamped = (i_cmd.speed > r_period) ? r_period : i_cmd.speed;
    assign w_pos_ext       = PW_EXT'(r_position);
    assign w_npos_ext      = PW_EXT'(n_position);
    assign w_diff          = i_cmd.angle_value - w_pos_ext[31:0];
    assign w_positive      = (w_diff != 32'd0) && !w_diff[31];

    always_comb begin
        n_run      = r_run;
        n_position = r_position;
        n_target   = r_target;
        n_step     = r_step;
        n_speed    = r_speed;
        n_dir      = r_dir;
        n_pin      = r_pin;
        w_drive    = 1'b0;
        w_fin      = 1'b0;
        case (i_cmd.func)
            smseq_pkg::FUNC_TICK: begin
                if (r_run) begin
                    if (r_step == r_target) begin
                        n_step   = '0;
                        n_target = '0;
                        n_run    = 1'b0;
                        w_fin    = 1'b1;
                    end else begin
                        w_drive = 1'b1;
                        if (r_dir == smseq_pkg::DIR_FWD) begin
                            n_pin      = 1'b1;
                            n_position = r_position + POS_WIDTH'(1);
                        end else if (r_dir == smseq_pkg::DIR_REV) begin
                            n_pin      = 1'b0;
                            n_position = r_position - POS_WIDTH'(1);
                        end
                        n_step = r_step + 32'd1;
                    end
                end
            end
            smseq_pkg::FUNC_ABS_MOVE: begin
                n_speed  = w_speed_clamped;
                n_dir    = w_positive ? smseq_pkg::DIR_FWD : smseq_pkg::DIR_REV;
                n_target = w_positive ? w_diff : (32'd0 - w_diff);
                n_step   = '0;
            end
            smseq_pkg::FUNC_REL_TURN: begin
                n_speed  = w_speed_clamped;
                n_dir    = i_cmd.direction;
                n_target = i_cmd.angle_value;
                n_step   = '0;
            end
            smseq_pkg::FUNC_CONT_RUN: begin
                n_speed  = w_speed_clamped;
                n_dir    = i_cmd.direction;
                n_target = smseq_pkg::CONT_TARGET;
            end
            smseq_pkg::FUNC_RESET: begin
                n_run      = 1'b0;
                n_position = '0;
                n_target   = '0;
                n_step     = '0;
                n_speed    = '0;
                n_dir      = smseq_pkg::DIR_REV;
                n_pin      = 1'b0;
            end
            smseq_pkg::FUNC_START: begin
                n_run = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.running       = n_run;
        o_res.drive_enable  = w_drive;
        o_res.dir_level     = n_pin;
        o_res.counter_load  = w_drive ? ({1'b0, r_period} + {1'b0, r_speed}) : 17'd0;
        o_res.compare_value = w_drive ? (r_period - r_speed) : 16'd0;
        o_res.position      = w_npos_ext[31:0];
        o_res.steps_done    = n_step;
        o_res.finished      = w_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= smseq_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= 1'b0;
            r_position <= '0;
            r_target   <= '0;
            r_step     <= '0;
            r_speed    <= '0;
            r_dir      <= smseq_pkg::DIR_REV;
            r_pin      <= 1'b0;
        end else if (i_exec) begin
            r_run      <= n_run;
            r_position <= n_position;
            r_target   <= n_target;
            r_step     <= n_step;
            r_speed    <= n_speed;
            r_dir      <= n_dir;
            r_pin      <= n_pin;
        end
    end

    // a period written after the move was loaded can sit below the stored speed;
    // while the speed is within the period, load plus compare is twice the period
    a_timer_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_exec && w_drive && r_speed <= r_period) |->
        (o_res.counter_load + {1'b0, o_res.compare_value} == {r_period, 1'b0}))
        else $error("timer load and compare do not sum to twice the period");

    a_fin_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_exec && w_fin) |=> (!r_run && r_step == 32'd0 && r_target == 32'd0))
        else $error("finished move left the run state set");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= r_target)
        else $error("step count passed the target");

    a_drive_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_exec |-> !(w_drive && w_fin))
        else $error("step driven on the finishing tick");

    a_reset_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_exec && i_cmd.func == smseq_pkg::FUNC_RESET) |=>
        (r_position == '0 && !r_run && r_speed == 16'd0))
        else $error("reset command did not clear the move state");

endmodule

// ----- rtl/smseq_egress.sv -----
`timescale 1ns / 1ps
// Result register: holds one result beat until the receiver takes it.
// Depends on smseq_pkg.
module smseq_egress (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  smseq_pkg::t_result  i_res,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output smseq_pkg::t_result  o_res
);

    logic               r_valid;
    smseq_pkg::t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- rtl/stepper_move_sequencer.sv -----
`timescale 1ns / 1ps
// Top level of the stepper move sequencer.
// Depends on smseq_pkg, smseq_ingress, smseq_core and smseq_egress.
//
// Usage:
//   Slave channel (i_s_*) carries commands and step ticks, one per beat; the
//   command code travels in tuser. Every accepted beat yields exactly one
//   result beat on the master channel (o_m_*), in order.
//   Commands: tick, absolute move, relative turn, continuous run, reset,
//   start. A tick while running either drives one step (timer load and
//   compare are period plus and minus the clamped speed) or finishes the move.
//   i_cfg_we/i_cfg_wdata write the timer period (also the speed limit); write
//   it only while no beat is in flight.
// Pipeline: an accepted input beat passes the input register, then the
//   result register, before its result beat is valid. Throughput: one beat
//   per cycle while i_m_tready stays high; the execute step is combinational.
// Reset: i_rst_n (synchronous) clears all move state and the pipeline,
//   and loads the period with 1000.
// Stall: when the receiver holds i_m_tready low, the result register holds;
//   an empty input register takes one more beat, then o_s_tready drops.
module stepper_move_sequencer #(
    parameter int POS_WIDTH = smseq_pkg::POS_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // register write
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,     // pwm_period
    // command stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [55:0]  i_s_tdata,       // speed[15:0], direction[17:16], angle_value[49:18]
    input  logic [2:0]   i_s_tuser,       // func[2:0]
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata        // running[0], drive_enable[1], dir_level[2],
                                          // counter_load[19:3], compare_value[35:20],
                                          // position[67:36], steps_done[99:68],
                                          // finished[100]
);

    smseq_pkg::t_cmd    w_in_cmd;
    smseq_pkg::t_cmd    w_exec_cmd;
    smseq_pkg::t_result w_core_res;
    smseq_pkg::t_result w_out_res;
    logic               w_ing_valid;
    logic               w_egr_ready;
    logic               w_exec;

    // unpack the incoming beat
    assign w_in_cmd.func        = i_s_tuser;
    assign w_in_cmd.speed       = i_s_tdata[15:0];
    assign w_in_cmd.direction   = i_s_tdata[17:16];
    assign w_in_cmd.angle_value = i_s_tdata[49:18];

    // execute when a command is held and the result register has room
    assign w_exec = w_ing_valid && w_egr_ready;

    smseq_ingress u_ingress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_cmd   (w_in_cmd),
        .i_take  (w_egr_ready),
        .o_valid (w_ing_valid),
        .o_cmd   (w_exec_cmd)
    );

    smseq_core #(
        .POS_WIDTH (POS_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_exec      (w_exec),
        .i_cmd       (w_exec_cmd),
        .o_res       (w_core_res)
    );

    smseq_egress u_egress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_exec),
        .i_res   (w_core_res),
        .o_ready (w_egr_ready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (w_out_res)
    );

    // pack the result beat, first field in the low bits, zero pad to bytes
    assign o_m_tdata = {3'b000,
                        w_out_res.finished,
                        w_out_res.steps_done,
                        w_out_res.position,
                        w_out_res.compare_value,
                        w_out_res.counter_load,
                        w_out_res.dir_level,
                        w_out_res.drive_enable,
                        w_out_res.running};

endmodule
